// File: rtl/trimmed_mean_inductance_calc_top_assert.svh
// Assertion macros used by the checker of the trimmed mean block.
// Depends on nothing; the user supplies clk and rst_n in scope.
`ifndef TRIMMED_MEAN_INDUCTANCE_CALC_TOP_ASSERT_SVH
`define TRIMMED_MEAN_INDUCTANCE_CALC_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define TMIC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define TMIC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/tmic_pkg.sv
// Shared constants, types and state codes of the trimmed mean block.
// Used by every module of the block; depends on nothing.
package tmic_pkg;

    // Window and field sizes.
    localparam int WINDOW_LEN = 52;
    localparam int CNT_W      = $clog2(WINDOW_LEN);
    localparam int SAMPLE_W   = 16;
    localparam int TOTAL_W    = 22;
    localparam int PR_W       = 20;
    localparam int TRIM_DIV   = WINDOW_LEN - 2;

    // Parallel resistance: RP = RP_NUM / (RP_DEN_BASE + RP_SLOPE * trimmed sum).
    localparam logic [63:0] RP_NUM      = 64'd18418752000 * 64'(TRIM_DIV) * 64'd4096;
    localparam logic [63:0] RP_DEN_BASE = 64'd24624 * 64'(TRIM_DIV) * 64'd4096;
    localparam int          SLOPE_W     = 20;
    localparam logic [SLOPE_W-1:0] RP_SLOPE = 20'd744922;
    localparam logic [63:0] RP_DEN_MAX  =
        RP_DEN_BASE + 64'(RP_SLOPE) * 64'(TRIM_DIV) * 64'd65535;
    localparam int RP_NUM_W = $clog2(RP_NUM + 64'd1);
    localparam int DEN_W    = $clog2(RP_DEN_MAX + 64'd1);

    // Shared multiplier sizes.
    localparam int MUL_W   = 2 * SAMPLE_W;
    localparam int MUL_P_W = 2 * MUL_W;

    // Trimmed mean by reciprocal: floor(x / TRIM_DIV) = (x * MEAN_RCP) >> MEAN_SH.
    // The shift adds the divisor's bit count to the sum width, which keeps the
    // rounding error of the reciprocal below one step for every sum.
    localparam int          MEAN_SH  = TOTAL_W + $clog2(TRIM_DIV);
    localparam logic [63:0] MEAN_RCP =
        ((64'd1 << MEAN_SH) + 64'(TRIM_DIV) - 64'd1) / 64'(TRIM_DIV);

    // Inductance by reciprocal: floor(x / IND_DIV) = (x * IND_RCP) >> IND_SH.
    // With a shift of 48 the reciprocal fits 32 bits and stays exact for any
    // 32-bit square.
    localparam logic [63:0] IND_DIV = 64'd120596;
    localparam int          IND_SH  = 48;
    localparam logic [63:0] IND_RCP = ((64'd1 << IND_SH) + IND_DIV - 64'd1) / IND_DIV;

    // Divider sizes for the resistance division.
    localparam int DIV_N_W   = RP_NUM_W;
    localparam int DIV_D_W   = DEN_W;
    localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

    // Stream payload sizes.
    localparam int IN_DATA_W     = 2 * SAMPLE_W;
    localparam int OUT_FIELDS_W  = 3 * SAMPLE_W + PR_W;
    localparam int OUT_DATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;

    // End-of-window snapshot handed from the accumulator to the sequencer.
    typedef struct packed {
        logic                win_end;
        logic [TOTAL_W-1:0]  prox_total;
        logic [TOTAL_W-1:0]  freq_total;
        logic [SAMPLE_W-1:0] prox_lo;
        logic [SAMPLE_W-1:0] prox_hi;
        logic [SAMPLE_W-1:0] freq_lo;
        logic [SAMPLE_W-1:0] freq_hi;
    } win_snap_t;

    // Divider request and response.
    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] dividend;
        logic [DIV_D_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [DIV_N_W-1:0] quotient;
    } div_rsp_t;

    // One result beat.
    typedef struct packed {
        logic [SAMPLE_W-1:0] inductance;
        logic [PR_W-1:0]     parallel_resistance;
        logic [SAMPLE_W-1:0] freq_mean;
        logic [SAMPLE_W-1:0] prox_mean;
    } result_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        SQ_WAIT,
        SQ_TRIM,
        SQ_PMUL,
        SQ_FMUL,
        SQ_SQR,
        SQ_IMUL,
        SQ_SLOPE,
        SQ_RDIV_L,
        SQ_RDIV_W,
        SQ_LOAD
    } seq_state_t;

endpackage

// File: rtl/trimmed_mean_inductance_calc_top.sv
// Top level of the trimmed mean inductance block.
// Depends on tmic_pkg, tmic_accum, tmic_div and tmic_seq.
//
// Usage:
// - The slave stream carries one proximity and one frequency sample per beat.
//   Mid-window beats are taken one per cycle while tready is high and
//   only update the running sums, minima and maxima.
// - The last beat of each 52-beat window starts the end-of-window work: the
//   trim, the shared multiplier (means, square, inductance, resistance
//   denominator) and the resistance division at one quotient bit per cycle
//   in 52 steps. tready drops after the last beat, once the sequencer leaves
//   its wait state, and stays low until the result is loaded.
// - The master stream presents the result beat once the division is done:
//   both trimmed means, the parallel resistance, the inductance.
// - The result sits in an output register; new samples are taken while it
//   waits. If the receiver still stalls when the next window's result is
//   ready, the block holds with tready low until the beat is taken.
// - Reset clears the window (sums to zero, minima to all ones, maxima to
//   zero) and drops any pending result.
module trimmed_mean_inductance_calc_top
    import tmic_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // Fields from bit 0: prox_sample[15:0], freq_sample[15:0].
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // Fields from bit 0: prox_mean[15:0], freq_mean[15:0],
    // parallel_resistance[19:0], inductance[15:0], zero padding.
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    win_snap_t snap;
    div_req_t  div_req;
    div_rsp_t  div_rsp;
    result_t   result;
    logic      beat;

    assign beat = s_axis_tvalid && s_axis_tready;

    tmic_accum u_accum (
        .clk         (clk),
        .rst_n       (rst_n),
        .beat        (beat),
        .prox_sample (s_axis_tdata[SAMPLE_W-1:0]),
        .freq_sample (s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W]),
        .snap        (snap)
    );

    tmic_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    tmic_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .snap      (snap),
        .rsp       (div_rsp),
        .req       (div_req),
        .in_ready  (s_axis_tready),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .result    (result)
    );

    // Pack the result beat, lowest field first.
    assign m_axis_tdata = {{(OUT_DATA_W - OUT_FIELDS_W){1'b0}}, result};

endmodule

// File: rtl/tmic_accum.sv
// Per-window accumulator: running sums, minima and maxima of both channels.
// Depends on tmic_pkg; hands an end-of-window snapshot to the sequencer.
module tmic_accum
    import tmic_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                beat,
    input  logic [SAMPLE_W-1:0] prox_sample,
    input  logic [SAMPLE_W-1:0] freq_sample,
    output win_snap_t           snap
);

    logic [CNT_W-1:0]    count_reg, count_next;
    logic [TOTAL_W-1:0]  ptot_reg, ptot_next;
    logic [TOTAL_W-1:0]  ftot_reg, ftot_next;
    logic [SAMPLE_W-1:0] plo_reg, plo_next;
    logic [SAMPLE_W-1:0] phi_reg, phi_next;
    logic [SAMPLE_W-1:0] flo_reg, flo_next;
    logic [SAMPLE_W-1:0] fhi_reg, fhi_next;
    logic                end_reg, end_next;
    win_snap_t           snap_reg, snap_next;
    logic                last;

    // Update the running values and capture them on the last beat of a window.
    always_comb
    begin
        last       = (count_reg == CNT_W'(WINDOW_LEN - 1));
        count_next = count_reg;
        ptot_next  = ptot_reg;
        ftot_next  = ftot_reg;
        plo_next   = plo_reg;
        phi_next   = phi_reg;
        flo_next   = flo_reg;
        fhi_next   = fhi_reg;
        end_next   = 1'b0;
        snap_next  = snap_reg;
        if (beat)
        begin
            plo_next   = (prox_sample < plo_reg) ? prox_sample : plo_reg;
            phi_next   = (prox_sample > phi_reg) ? prox_sample : phi_reg;
            flo_next   = (freq_sample < flo_reg) ? freq_sample : flo_reg;
            fhi_next   = (freq_sample > fhi_reg) ? freq_sample : fhi_reg;
            ptot_next  = ptot_reg + TOTAL_W'(prox_sample);
            ftot_next  = ftot_reg + TOTAL_W'(freq_sample);
            count_next = count_reg + 1'b1;
            if (last)
            begin
                snap_next.prox_total = ptot_next;
                snap_next.freq_total = ftot_next;
                snap_next.prox_lo    = plo_next;
                snap_next.prox_hi    = phi_next;
                snap_next.freq_lo    = flo_next;
                snap_next.freq_hi    = fhi_next;
                end_next             = 1'b1;
                // Start the next window from the cleared values.
                count_next = '0;
                ptot_next  = '0;
                ftot_next  = '0;
                plo_next   = '1;
                phi_next   = '0;
                flo_next   = '1;
                fhi_next   = '0;
            end
        end
        snap_next.win_end = end_next;
    end

    // Window state, cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ptot_reg  <= '0;
            ftot_reg  <= '0;
            plo_reg   <= '1;
            phi_reg   <= '0;
            flo_reg   <= '1;
            fhi_reg   <= '0;
            end_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ptot_reg  <= ptot_next;
            ftot_reg  <= ftot_next;
            plo_reg   <= plo_next;
            phi_reg   <= phi_next;
            flo_reg   <= flo_next;
            fhi_reg   <= fhi_next;
            end_reg   <= end_next;
        end
    end

    // Snapshot payload needs no reset.
    always_ff @(posedge clk)
    begin
        snap_reg <= snap_next;
    end

    always_comb
    begin
        snap         = snap_reg;
        snap.win_end = end_reg;
    end

endmodule

// File: rtl/tmic_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on tmic_pkg; driven by the sequencer through div_req_t / div_rsp_t.
module tmic_div
    import tmic_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_D_W-1:0]   rem_reg, rem_next;
    logic [DIV_N_W-1:0]   quo_reg, quo_next;
    logic [DIV_D_W-1:0]   dvs_reg, dvs_next;
    logic [DIV_D_W:0]     rem_sh;
    logic [DIV_D_W:0]     rem_sub;
    logic                 fits;

    // One shift-compare-subtract step; the dividend shifts out as quotient bits shift in.
    always_comb
    begin
        rem_sh    = {rem_reg, quo_reg[DIV_N_W-1]};
        rem_sub   = rem_sh - {1'b0, dvs_reg};
        fits      = (rem_sh >= {1'b0, dvs_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_N_W);
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? rem_sub[DIV_D_W-1:0] : rem_sh[DIV_D_W-1:0];
            quo_next = {quo_reg[DIV_N_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// File: rtl/tmic_seq.sv
// Sequencer: trims the window sums, forms the means, the square, the
// inductance and the resistance denominator on one shared multiplier, runs
// the resistance division on the divider and holds the result beat.
// Depends on tmic_pkg and on tmic_div through div_req_t / div_rsp_t.
module tmic_seq
    import tmic_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  win_snap_t snap,
    input  div_rsp_t  rsp,
    output div_req_t  req,
    output logic      in_ready,
    input  logic      out_ready,
    output logic      out_valid,
    output result_t   result
);

    seq_state_t                   state_reg, state_next;
    logic                         out_valid_reg, out_valid_next;
    result_t                      result_reg, result_next;
    logic [TOTAL_W-1:0]           sp_reg, sp_next;
    logic [TOTAL_W-1:0]           sf_reg, sf_next;
    logic [SAMPLE_W-1:0]          pm_reg, pm_next;
    logic [SAMPLE_W-1:0]          fm_reg, fm_next;
    logic [DEN_W-1:0]             den_reg, den_next;
    logic [2*SAMPLE_W-1:0]        fsq_reg, fsq_next;
    logic [PR_W-1:0]              rp_reg, rp_next;
    logic [SAMPLE_W-1:0]          ind_reg, ind_next;
    logic [MUL_W-1:0]             mul_a;
    logic [MUL_W-1:0]             mul_b;
    logic [MUL_P_W-1:0]           mul_p;

    // Shared multiplier; the state picks its operands.
    assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

    // Next state, multiplier operands, divider request and result register.
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        result_next    = result_reg;
        sp_next        = sp_reg;
        sf_next        = sf_reg;
        pm_next        = pm_reg;
        fm_next        = fm_reg;
        den_next       = den_reg;
        fsq_next       = fsq_reg;
        rp_next        = rp_reg;
        ind_next       = ind_reg;
        mul_a          = MUL_W'(sp_reg);
        mul_b          = MUL_W'(MEAN_RCP);
        req.start      = 1'b0;
        req.dividend   = DIV_N_W'(RP_NUM);
        req.divisor    = DIV_D_W'(den_reg);

        // The held beat leaves when the receiver takes it.
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            SQ_WAIT:
            begin
                if (snap.win_end)
                begin
                    state_next = SQ_TRIM;
                end
            end
            SQ_TRIM:
            begin
                sp_next = snap.prox_total
                        - (TOTAL_W'(snap.prox_lo) + TOTAL_W'(snap.prox_hi));
                sf_next = snap.freq_total
                        - (TOTAL_W'(snap.freq_lo) + TOTAL_W'(snap.freq_hi));
                state_next = SQ_PMUL;
            end
            SQ_PMUL:
            begin
                // Proximity mean by reciprocal multiplication.
                pm_next    = mul_p[MEAN_SH +: SAMPLE_W];
                state_next = SQ_FMUL;
            end
            SQ_FMUL:
            begin
                mul_a      = MUL_W'(sf_reg);
                fm_next    = mul_p[MEAN_SH +: SAMPLE_W];
                state_next = SQ_SQR;
            end
            SQ_SQR:
            begin
                mul_a      = MUL_W'(fm_reg);
                mul_b      = MUL_W'(fm_reg);
                fsq_next   = mul_p[MUL_W-1:0];
                state_next = SQ_IMUL;
            end
            SQ_IMUL:
            begin
                // Inductance by reciprocal multiplication of the square.
                mul_a      = fsq_reg;
                mul_b      = MUL_W'(IND_RCP);
                ind_next   = mul_p[IND_SH +: SAMPLE_W];
                state_next = SQ_SLOPE;
            end
            SQ_SLOPE:
            begin
                mul_b      = MUL_W'(RP_SLOPE);
                den_next   = DEN_W'(RP_DEN_BASE) + mul_p[DEN_W-1:0];
                state_next = SQ_RDIV_L;
            end
            SQ_RDIV_L:
            begin
                req.start  = 1'b1;
                state_next = SQ_RDIV_W;
            end
            SQ_RDIV_W:
            begin
                if (rsp.done)
                begin
                    rp_next    = rsp.quotient[PR_W-1:0];
                    state_next = SQ_LOAD;
                end
            end
            SQ_LOAD:
            begin
                // Wait for the output register to be free.
                if (!out_valid_reg || out_ready)
                begin
                    result_next.prox_mean           = pm_reg;
                    result_next.freq_mean           = fm_reg;
                    result_next.parallel_resistance = rp_reg;
                    result_next.inductance          = ind_reg;
                    out_valid_next                  = 1'b1;
                    state_next                      = SQ_WAIT;
                end
            end
            default:
            begin
                state_next = SQ_WAIT;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SQ_WAIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working values and result payload.
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        sp_reg     <= sp_next;
        sf_reg     <= sf_next;
        pm_reg     <= pm_next;
        fm_reg     <= fm_next;
        den_reg    <= den_next;
        fsq_reg    <= fsq_next;
        rp_reg     <= rp_next;
        ind_reg    <= ind_next;
    end

    assign in_ready  = (state_reg == SQ_WAIT);
    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

// File: rtl/tmic_checker.sv
// Port-level checker for the trimmed mean block, bound to the top level.
// Depends on tmic_pkg and trimmed_mean_inductance_calc_top_assert.svh.
`include "trimmed_mean_inductance_calc_top_assert.svh"

module tmic_checker
    import tmic_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [IN_DATA_W-1:0]  s_axis_tdata,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // A stalled result beat keeps its data.
    `TMIC_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result beat changed while stalled")

    // A new result only appears after the input side was held off.
    `TMIC_ASSERT_IMP(a_out_after_busy, $rose(m_axis_tvalid), $past(!s_axis_tready), "result rose without end-of-window work")

    // Resistance and inductance stay in their ranges.
    `TMIC_ASSERT_IMP(a_out_range, m_axis_tvalid, (m_axis_tdata[51:32] <= 20'd748000) && (m_axis_tdata[67:52] <= 16'd35613), "result field out of range")

    // Inductance agrees with the frequency mean of the same beat.
    `TMIC_ASSERT_IMP(a_ind_match, m_axis_tvalid, ((32'(m_axis_tdata[31:16]) * 32'(m_axis_tdata[31:16])) / 32'd120596) == 32'(m_axis_tdata[67:52]), "inductance does not match frequency mean")

endmodule

bind trimmed_mean_inductance_calc_top tmic_checker u_tmic_checker (.*);
